FILE: src/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg: shared types and constants for the swap slot allocator
// Fixed store sizes, request and status codes, controller state, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int DISK_SLOTS   = 4096;
  localparam int DISK_AW      = 12;
  localparam int DCNT_W       = 13;
  localparam int POOL_ENTRIES = 64;
  localparam int POOL_AW      = 6;
  localparam int PCNT_W       = 7;
  localparam int WORD_BITS    = 32;
  localparam int BIT_AW       = 5;
  localparam int BMAP_WORDS   = DISK_SLOTS / WORD_BITS;
  localparam int BMAP_AW      = DISK_AW - BIT_AW;
  localparam int OWNER_BITS   = 16;
  localparam int CSIZE_W      = 14;
  localparam int SSIZE_W      = 12;
  localparam int HALF_PAGE    = 2048;
  localparam int MIN_STORED   = 8;
  localparam int SECT_SHIFT   = 3;
  localparam int LBA_W        = 48;
  localparam int LBA_OUT_W    = 49;

  typedef enum logic [1:0] {
    REQ_ALLOC     = 2'd0,
    REQ_FREE      = 2'd1,
    REQ_SET_OWNER = 2'd2,
    REQ_NOP       = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOT_LIVE = 2'd2
  } stat_t;

  localparam logic [1:0] CFG_DISK_COUNT = 2'd0;
  localparam logic [1:0] CFG_POOL_COUNT = 2'd1;
  localparam logic [1:0] CFG_START_LBA  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FREE
  } state_t;

  typedef struct packed {
    logic clear_start;
    logic clear_step;
    logic latch;
    logic decode;
    logic scan;
    logic free_chk;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic go_scan;
    logic go_free;
    logic scan_stop;
  } dp_stat_t;

endpackage

FILE: src/ssa_ctrl.sv
// ----------------------------------------------------------------------------
// ssa_ctrl: request sequencer
// Steps through store clearing, request decode, disk bitmap scan and free.
// ----------------------------------------------------------------------------
module ssa_ctrl
  import ssa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       cfg_clear,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        priority if (cfg_clear) state_next = S_CLEAR;
        else if (start) state_next = S_DECODE;
        else state_next = S_IDLE;
      end
      S_DECODE: begin
        priority if (stat.go_scan) state_next = S_SCAN;
        else if (stat.go_free) state_next = S_FREE;
        else state_next = S_IDLE;
      end
      S_SCAN: begin
        if (stat.scan_stop) state_next = S_IDLE;
      end
      S_FREE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_CLEAR: cmd.clear_step = 1'b1;
      S_IDLE: begin
        cmd.clear_start = cfg_clear;
        cmd.latch       = start && !cfg_clear;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        cmd.finish = !stat.go_scan && !stat.go_free;
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.finish = stat.scan_stop;
      end
      S_FREE: begin
        cmd.free_chk = 1'b1;
        cmd.finish   = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: src/ssa_dp.sv
// ----------------------------------------------------------------------------
// ssa_dp: allocator datapath
// Bitmap and owner memories, pool bitmap, counters, cursor and result word.
// ----------------------------------------------------------------------------
module ssa_dp
  import ssa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  input  logic                  cfg_disk_wr,
  input  logic [DCNT_W-1:0]     disk_cnt,
  input  logic [PCNT_W-1:0]     pool_cnt,
  input  logic [LBA_W-1:0]      base_lba,
  input  logic [1:0]            req_type,
  input  logic [DISK_AW-1:0]    slot,
  input  logic                  in_pool,
  input  logic [OWNER_BITS-1:0] owner,
  input  logic [CSIZE_W-1:0]    compressed_size,
  output logic                  done,
  output logic [1:0]            status,
  output logic [DISK_AW-1:0]    slot_out,
  output logic                  pool_out,
  output logic [SSIZE_W-1:0]    stored_size,
  output logic [LBA_OUT_W-1:0]  lba,
  output logic [OWNER_BITS-1:0] released_owner,
  output logic [DCNT_W-1:0]     disk_used,
  output logic [PCNT_W-1:0]     pool_used
);

  // clearing pass
  logic [DISK_AW-1:0] clr_idx;
  logic               clr_pool;

  // latched request
  req_t                  q_req;
  logic [DISK_AW-1:0]    q_slot;
  logic                  q_pool;
  logic [OWNER_BITS-1:0] q_owner;
  logic [CSIZE_W-1:0]    q_csize;

  logic [DISK_AW-1:0]      cursor;
  logic [DCNT_W-1:0]       disk_count;
  logic [PCNT_W-1:0]       pool_count;
  logic [POOL_ENTRIES-1:0] pool_bmap;

  logic [WORD_BITS-1:0]  bmap_mem [BMAP_WORDS];
  logic [WORD_BITS-1:0]  bmap_rd;
  logic [OWNER_BITS-1:0] downer_mem [DISK_SLOTS];
  logic [OWNER_BITS-1:0] downer_rd;
  logic [OWNER_BITS-1:0] powner_mem [POOL_ENTRIES];
  logic [OWNER_BITS-1:0] powner_rd;

  logic [BMAP_AW-1:0] wptr, w0;
  logic               wrapped;

  // decode
  logic is_alloc, is_free, is_set;
  logic size_ok, pool_hit, disk_in, pool_in;
  logic [POOL_ENTRIES-1:0] avail;
  logic [POOL_AW-1:0]      pidx;
  logic [DCNT_W-1:0]       dc_m1;
  logic [BMAP_AW-1:0]      last_word;

  // scan
  logic [WORD_BITS-1:0] taken, free_bits;
  logic [BIT_AW-1:0]    fbit;
  logic                 found, exhausted, first_visit;
  logic [BMAP_AW-1:0]   wnext;
  logic [DISK_AW-1:0]   fidx;
  logic [DCNT_W-1:0]    fidx_p1;

  // free
  logic live;

  // memory ports
  logic                  bm_we;
  logic [BMAP_AW-1:0]    bm_waddr, bm_raddr;
  logic [WORD_BITS-1:0]  bm_wdata;
  logic                  do_we;
  logic [DISK_AW-1:0]    do_waddr;
  logic [OWNER_BITS-1:0] do_wdata;
  logic                  po_we;
  logic [POOL_AW-1:0]    po_waddr;
  logic [OWNER_BITS-1:0] po_wdata;

  // result
  stat_t                 r_status;
  logic [DISK_AW-1:0]    r_slot;
  logic                  r_pool;
  logic [SSIZE_W-1:0]    r_size;
  logic [LBA_OUT_W-1:0]  r_lba;
  logic [OWNER_BITS-1:0] r_owner;

  assign is_alloc = (q_req == REQ_ALLOC);
  assign is_free  = (q_req == REQ_FREE);
  assign is_set   = (q_req == REQ_SET_OWNER);
  assign size_ok  = (q_csize != '0) && (q_csize <= CSIZE_W'(HALF_PAGE));
  assign disk_in  = ({1'b0, q_slot} < disk_cnt);
  assign pool_in  = ({1'b0, q_slot} < DCNT_W'(pool_cnt));
  assign dc_m1    = disk_cnt - DCNT_W'(1);
  assign last_word = dc_m1[DISK_AW-1:BIT_AW];

  always_comb begin
    pidx = '0;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      avail[i] = !pool_bmap[i] && (PCNT_W'(i) < pool_cnt);
    end
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (avail[i]) pidx = POOL_AW'(i);
    end
  end
  assign pool_hit = size_ok && (|avail);

  // word under scan: used bits, bits past the disk end, and on the first
  // visit of the cursor word, bits below the cursor count as taken
  assign first_visit = !wrapped && (wptr == w0);
  always_comb begin
    fbit = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      taken[b] = bmap_rd[b]
        || ({1'b0, wptr, BIT_AW'(b)} >= disk_cnt)
        || (first_visit && (BIT_AW'(b) < cursor[BIT_AW-1:0]));
    end
    free_bits = ~taken;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) fbit = BIT_AW'(b);
    end
  end
  assign found     = |free_bits;
  assign exhausted = wrapped && (wptr == w0);
  assign wnext     = (!wrapped && (wptr == last_word)) ? '0 : wptr + BMAP_AW'(1);
  assign fidx      = {wptr, fbit};
  assign fidx_p1   = {1'b0, fidx} + DCNT_W'(1);

  assign live = q_pool ? (pool_in && pool_bmap[q_slot[POOL_AW-1:0]])
                       : (disk_in && bmap_rd[q_slot[BIT_AW-1:0]]);

  assign stat.clear_last = cmd.clear_step && (clr_idx == DISK_AW'(DISK_SLOTS - 1));
  assign stat.go_scan    = cmd.decode && is_alloc && !pool_hit && (disk_cnt != '0);
  assign stat.go_free    = cmd.decode && is_free;
  assign stat.scan_stop  = found || exhausted;

  // memory port selection
  always_comb begin
    bm_raddr = wnext;
    if (cmd.decode) bm_raddr = is_free ? q_slot[DISK_AW-1:BIT_AW]
                                       : cursor[DISK_AW-1:BIT_AW];
    bm_we = 1'b0;
    bm_waddr = clr_idx[BMAP_AW-1:0];
    bm_wdata = '0;
    do_we = 1'b0;
    do_waddr = clr_idx;
    do_wdata = '0;
    po_we = 1'b0;
    po_waddr = clr_idx[POOL_AW-1:0];
    po_wdata = '0;
    priority if (cmd.clear_step) begin
      bm_we = (clr_idx < DISK_AW'(BMAP_WORDS));
      do_we = 1'b1;
      po_we = clr_pool && (clr_idx < DISK_AW'(POOL_ENTRIES));
    end else if (cmd.decode && is_set) begin
      do_we = !q_pool && disk_in;
      do_waddr = q_slot;
      do_wdata = q_owner;
      po_we = q_pool && pool_in;
      po_waddr = q_slot[POOL_AW-1:0];
      po_wdata = q_owner;
    end else if (cmd.scan && found) begin
      bm_we = 1'b1;
      bm_waddr = wptr;
      bm_wdata = bmap_rd | (WORD_BITS'(1) << fbit);
    end else if (cmd.free_chk && live) begin
      bm_we = !q_pool;
      bm_waddr = q_slot[DISK_AW-1:BIT_AW];
      bm_wdata = bmap_rd & ~(WORD_BITS'(1) << q_slot[BIT_AW-1:0]);
      do_we = !q_pool;
      do_waddr = q_slot;
      po_we = q_pool;
      po_waddr = q_slot[POOL_AW-1:0];
    end else begin
      bm_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bm_we) bmap_mem[bm_waddr] <= bm_wdata;
    bmap_rd <= bmap_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (do_we) downer_mem[do_waddr] <= do_wdata;
    downer_rd <= downer_mem[q_slot];
  end

  always_ff @(posedge clk) begin
    if (po_we) powner_mem[po_waddr] <= po_wdata;
    powner_rd <= powner_mem[q_slot[POOL_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      clr_pool <= 1'b1;
    end else if (cmd.clear_start) begin
      clr_idx <= '0;
    end else if (cmd.clear_step) begin
      clr_idx <= clr_idx + DISK_AW'(1);
      if (stat.clear_last) clr_pool <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      q_req   <= req_t'(req_type);
      q_slot  <= slot;
      q_pool  <= in_pool;
      q_owner <= owner;
      q_csize <= compressed_size;
    end
    if (cmd.decode) begin
      wptr    <= cursor[DISK_AW-1:BIT_AW];
      w0      <= cursor[DISK_AW-1:BIT_AW];
      wrapped <= 1'b0;
    end else if (cmd.scan) begin
      wptr <= wnext;
      if (!wrapped && (wptr == last_word)) wrapped <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_disk_wr) begin
      cursor     <= '0;
      disk_count <= '0;
    end else if (cmd.scan && found) begin
      cursor     <= (fidx_p1 == disk_cnt) ? '0 : fidx_p1[DISK_AW-1:0];
      disk_count <= disk_count + DCNT_W'(1);
    end else if (cmd.free_chk && live && !q_pool && (disk_count != '0)) begin
      disk_count <= disk_count - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_count <= '0;
      pool_bmap  <= '0;
    end else if (cmd.decode && is_alloc && pool_hit) begin
      pool_count      <= pool_count + PCNT_W'(1);
      pool_bmap[pidx] <= 1'b1;
    end else if (cmd.free_chk && live && q_pool) begin
      if (pool_count != '0) pool_count <= pool_count - PCNT_W'(1);
      pool_bmap[q_slot[POOL_AW-1:0]] <= 1'b0;
    end
  end

  // result word
  always_comb begin
    r_status = STAT_OK;
    r_slot   = '0;
    r_pool   = 1'b0;
    r_size   = '0;
    r_lba    = '0;
    r_owner  = '0;
    priority if (cmd.decode) begin
      if (is_alloc && pool_hit) begin
        r_slot = DISK_AW'(pidx);
        r_pool = 1'b1;
        r_size = (q_csize < CSIZE_W'(MIN_STORED)) ? SSIZE_W'(MIN_STORED)
                                                  : q_csize[SSIZE_W-1:0];
      end else if (is_alloc) begin
        r_status = STAT_FULL;
      end
    end else if (cmd.scan) begin
      if (found) begin
        r_slot = fidx;
        r_lba  = {1'b0, base_lba} + (LBA_OUT_W'(fidx) << SECT_SHIFT);
      end else begin
        r_status = STAT_FULL;
      end
    end else if (cmd.free_chk) begin
      if (live) r_owner = q_pool ? powner_rd : downer_rd;
      else r_status = STAT_NOT_LIVE;
    end else begin
      r_status = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      status         <= r_status;
      slot_out       <= r_slot;
      pool_out       <= r_pool;
      stored_size    <= r_size;
      lba            <= r_lba;
      released_owner <= r_owner;
    end
  end

  assign disk_used = disk_count;
  assign pool_used = pool_count;

`ifndef ASSERT_OFF
  a_disk_count_bound: assert property (@(posedge clk) disable iff (rst)
    disk_count <= disk_cnt)
    else $error("disk count exceeds usable slots");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (disk_cnt == '0) ? (cursor == '0) : ({1'b0, cursor} < disk_cnt))
    else $error("cursor outside disk range");

  a_pool_count: assert property (@(posedge clk) disable iff (rst)
    pool_count == PCNT_W'($countones(pool_bmap)))
    else $error("pool count disagrees with pool bitmap");
`endif

endmodule

FILE: src/swap_slot_allocator.sv
// ----------------------------------------------------------------------------
// swap_slot_allocator: pool and disk swap slot allocator
// Hands out, frees and tags slots in a compressed pool and a disk area.
// ----------------------------------------------------------------------------
// A request is taken when start is high, busy is low and disk_slot_count is
// not written in that cycle; its single result word appears on the result
// ports with done high for exactly one cycle and must be captured then.
// Set-owner, no-op, pool allocates and allocates that fail at once finish in
// the decode state; a free goes on to a free state. A disk allocate scans the
// used bitmap one 32-slot word per cycle from the next-fit cursor. After
// reset, and after each write of disk_slot_count made while idle, the block
// clears its owner and bitmap memories with busy high; configuration writes
// are still taken then. disk_used and pool_used show the live counts.
// ----------------------------------------------------------------------------
module swap_slot_allocator
  import ssa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [LBA_W-1:0]      cfg_data,
  // request
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            req_type,
  input  logic [DISK_AW-1:0]    slot,
  input  logic                  in_pool,
  input  logic [OWNER_BITS-1:0] owner,
  input  logic [CSIZE_W-1:0]    compressed_size,
  // result
  output logic                  done,
  output logic [1:0]            status,
  output logic [DISK_AW-1:0]    slot_out,
  output logic                  pool_out,
  output logic [SSIZE_W-1:0]    stored_size,
  output logic [LBA_OUT_W-1:0]  lba,
  output logic [OWNER_BITS-1:0] released_owner,
  output logic [DCNT_W-1:0]     disk_used,
  output logic [PCNT_W-1:0]     pool_used
);

  logic [DCNT_W-1:0] disk_cnt;
  logic [PCNT_W-1:0] pool_cnt;
  logic [LBA_W-1:0]  base_lba;
  logic              cfg_disk_wr;
  ctrl_cmd_t         cmd;
  dp_stat_t          stat;

  assign cfg_disk_wr = cfg_we && (cfg_index == CFG_DISK_COUNT);

  // config registers, counts saturated to store sizes
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_cnt <= '0;
      pool_cnt <= '0;
      base_lba <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DISK_COUNT: disk_cnt <= (cfg_data[DCNT_W-1:0] > DCNT_W'(DISK_SLOTS))
                                    ? DCNT_W'(DISK_SLOTS) : cfg_data[DCNT_W-1:0];
        CFG_POOL_COUNT: pool_cnt <= (cfg_data[PCNT_W-1:0] > PCNT_W'(POOL_ENTRIES))
                                    ? PCNT_W'(POOL_ENTRIES) : cfg_data[PCNT_W-1:0];
        CFG_START_LBA:  base_lba <= cfg_data;
        default: ;
      endcase
    end
  end

  ssa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_clear (cfg_disk_wr),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  ssa_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_disk_wr     (cfg_disk_wr),
    .disk_cnt        (disk_cnt),
    .pool_cnt        (pool_cnt),
    .base_lba        (base_lba),
    .req_type        (req_type),
    .slot            (slot),
    .in_pool         (in_pool),
    .owner           (owner),
    .compressed_size (compressed_size),
    .done            (done),
    .status          (status),
    .slot_out        (slot_out),
    .pool_out        (pool_out),
    .stored_size     (stored_size),
    .lba             (lba),
    .released_owner  (released_owner),
    .disk_used       (disk_used),
    .pool_used       (pool_used)
  );

endmodule
